### rtl/core/tile_map_renderer_defines.svh
`ifndef TILE_MAP_RENDERER_DEFINES_SVH
`define TILE_MAP_RENDERER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tmr_pkg.sv
`default_nettype none

package tmr_pkg;

  localparam int MAP_SIDE   = 32;
  localparam int TILE_BYTES = 16;
  localparam int TILE_COUNT = 256;

  localparam int MAP_SIZE  = MAP_SIDE * MAP_SIDE;
  localparam int DATA_SIZE = TILE_COUNT * TILE_BYTES;
  localparam int TILE_ROWS = TILE_BYTES / 2;

  localparam int COORD_IN_W = 5;
  localparam int COORD_W    = (MAP_SIDE > 1) ? $clog2(MAP_SIDE) : 1;
  localparam int MAP_AW     = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int TILE_W     = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int ROW_W      = $clog2(TILE_ROWS);
  localparam int WORDS      = TILE_COUNT * TILE_ROWS;
  localparam int WORD_AW    = $clog2(WORDS);
  localparam int PIX_W      = 8;

  typedef enum logic [1:0] {
    ACT_MAP_WR  = 2'd0,
    ACT_TILE_WR = 2'd1,
    ACT_RENDER  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_ROW,
    ST_EMIT
  } state_t;

  // slave tdata, lowest field last
  typedef struct packed {
    logic [1:0]            pad;
    logic [COORD_IN_W-1:0] tile_row;
    logic [COORD_IN_W-1:0] tile_col;
    logic [7:0]            data;
    logic [11:0]           address;
  } s_data_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // master tdata, lowest field last
  typedef struct packed {
    logic [5:0]       pad;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [1:0]       color_index;
    logic [PIX_W-1:0] pixel_y;
    logic [PIX_W-1:0] pixel_x;
  } m_data_t;

  localparam int S_TDATA_W = $bits(s_data_t);
  localparam int M_TDATA_W = $bits(m_data_t);

  typedef struct packed {
    logic map_wr;
    logic tile_wr;
    logic start;
    logic row_load;
    logic pix_adv;
  } cmd_t;

  typedef struct packed {
    logic row_end;
    logic tile_end;
  } status_t;

  typedef logic [COORD_W-1:0] coord_tbl_t [32];
  typedef logic [TILE_W-1:0]  tile_tbl_t  [256];

  function automatic coord_tbl_t build_coord_wrap();
    coord_tbl_t t;
    for (int i = 0; i < 32; i++) t[i] = COORD_W'(i % MAP_SIDE);
    return t;
  endfunction

  function automatic tile_tbl_t build_tile_wrap();
    tile_tbl_t t;
    for (int i = 0; i < 256; i++) t[i] = TILE_W'(i % TILE_COUNT);
    return t;
  endfunction

  localparam coord_tbl_t COORD_WRAP = build_coord_wrap();
  localparam tile_tbl_t  TILE_WRAP  = build_tile_wrap();

  function automatic rgb_t palette(input logic [1:0] ci);
    rgb_t c;
    unique case (ci)
      2'd0: c = '{red: 8'h9a, green: 8'hc8, blue: 8'heb};
      2'd1: c = '{red: 8'hf4, green: 8'hcf, blue: 8'hdf};
      2'd2: c = '{red: 8'hf7, green: 8'hf6, blue: 8'hcf};
      2'd3: c = '{red: 8'h57, green: 8'h84, blue: 8'hba};
      default: c = '{red: 8'h9a, green: 8'hc8, blue: 8'heb};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tmr_ctrl.sv
`default_nettype none

module tmr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  input  wire logic [1:0]       s_axis_tuser,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output tmr_pkg::cmd_t         cmd,
  input  wire tmr_pkg::status_t status
);

  tmr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      tmr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (tmr_pkg::action_t'(s_axis_tuser))
            tmr_pkg::ACT_MAP_WR:  cmd.map_wr  = 1'b1;
            tmr_pkg::ACT_TILE_WR: cmd.tile_wr = 1'b1;
            tmr_pkg::ACT_RENDER: begin
              cmd.start  = 1'b1;
              state_next = tmr_pkg::ST_MAP;
            end
            default: ;
          endcase
        end
      end
      // map byte lands this cycle, first tile row is being fetched
      tmr_pkg::ST_MAP: state_next = tmr_pkg::ST_ROW;
      tmr_pkg::ST_ROW: begin
        cmd.row_load = 1'b1;
        state_next   = tmr_pkg::ST_EMIT;
      end
      tmr_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cmd.pix_adv = 1'b1;
          if (status.tile_end) state_next = tmr_pkg::ST_IDLE;
        end
      end
      default: state_next = tmr_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tmr_datapath.sv
`default_nettype none

module tmr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [tmr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  wire tmr_pkg::cmd_t                 cmd,
  output tmr_pkg::status_t                   status,
  output logic [tmr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast
);

  tmr_pkg::s_data_t in_d;
  tmr_pkg::m_data_t out_d;
  tmr_pkg::rgb_t    rgb;

  logic [7:0]  map_mem  [tmr_pkg::MAP_SIZE];
  logic [15:0] tile_mem [tmr_pkg::WORDS];

  logic [tmr_pkg::COORD_W-1:0] col_w, row_w, col_q, row_q;
  logic [tmr_pkg::MAP_AW-1:0]  map_wr_idx, map_rd_idx;
  logic [tmr_pkg::WORD_AW-1:0] tile_wr_idx, tile_rd_idx;
  logic [tmr_pkg::TILE_W-1:0]  tile;
  logic [7:0]                  map_q;
  logic [15:0]                 tile_q;
  logic [7:0]                  hi_sr, lo_sr;
  logic [tmr_pkg::ROW_W-1:0]   fetch_row, row_cnt;
  logic [2:0]                  bit_cnt;
  logic                        map_in_range, tile_in_range;
  logic [1:0]                  ci;

  assign in_d  = tmr_pkg::s_data_t'(s_axis_tdata);
  assign col_w = tmr_pkg::COORD_WRAP[in_d.tile_col];
  assign row_w = tmr_pkg::COORD_WRAP[in_d.tile_row];

  assign map_in_range  = int'(in_d.address) < tmr_pkg::MAP_SIZE;
  assign tile_in_range = int'(in_d.address) < tmr_pkg::DATA_SIZE;
  assign map_wr_idx    = tmr_pkg::MAP_AW'(in_d.address);
  assign map_rd_idx    = tmr_pkg::MAP_AW'(int'(row_w) * tmr_pkg::MAP_SIDE + int'(col_w));
  assign tile_wr_idx   = tmr_pkg::WORD_AW'(in_d.address[11:1]);

  // one word holds both plane bytes of a tile row
  assign tile        = tmr_pkg::TILE_WRAP[map_q];
  assign tile_rd_idx = tmr_pkg::WORD_AW'({tile, fetch_row});

  always_ff @(posedge clk) begin
    if (cmd.map_wr && map_in_range) map_mem[map_wr_idx] <= in_d.data;
    if (cmd.start) map_q <= map_mem[map_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.tile_wr && tile_in_range) begin
      if (in_d.address[0]) tile_mem[tile_wr_idx][15:8] <= in_d.data;
      else                 tile_mem[tile_wr_idx][7:0]  <= in_d.data;
    end
    tile_q <= tile_mem[tile_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_q <= col_w;
      row_q <= row_w;
    end
  end

  // next row is prefetched while the current one is shifted out
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_row <= '0;
      row_cnt   <= '0;
      bit_cnt   <= '0;
    end else if (cmd.start) begin
      fetch_row <= '0;
    end else if (cmd.row_load) begin
      fetch_row <= fetch_row + 1'b1;
      row_cnt   <= '0;
      bit_cnt   <= '0;
    end else if (cmd.pix_adv) begin
      if (status.row_end) begin
        fetch_row <= fetch_row + 1'b1;
        row_cnt   <= row_cnt + 1'b1;
        bit_cnt   <= '0;
      end else begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load || (cmd.pix_adv && status.row_end)) begin
      hi_sr <= tile_q[7:0];
      lo_sr <= tile_q[15:8];
    end else if (cmd.pix_adv) begin
      hi_sr <= {hi_sr[6:0], 1'b0};
      lo_sr <= {lo_sr[6:0], 1'b0};
    end
  end

  assign status.row_end  = bit_cnt == 3'd7;
  assign status.tile_end = status.row_end && (row_cnt == tmr_pkg::ROW_W'(tmr_pkg::TILE_ROWS - 1));

  assign ci  = {hi_sr[7], lo_sr[7]};
  assign rgb = tmr_pkg::palette(ci);

  always_comb begin
    out_d             = '0;
    out_d.pixel_x     = tmr_pkg::PIX_W'({col_q, bit_cnt});
    out_d.pixel_y     = tmr_pkg::PIX_W'({row_q, row_cnt});
    out_d.color_index = ci;
    out_d.red         = rgb.red;
    out_d.green       = rgb.green;
    out_d.blue        = rgb.blue;
  end

  assign m_axis_tdata = out_d;
  assign m_axis_tlast = status.tile_end;

endmodule

`default_nettype wire

### rtl/core/tile_map_renderer.sv
// write transactions leave the controller idle, so the block is ready again the next cycle
// render: after acceptance the controller passes ST_MAP and ST_ROW (map read, then tile row read),
// then one pixel per cycle while m_axis_tready is high, 64 per tile; input waits till done
// each store has a single read port: one map read, one tile row per 8 pixels
// synchronous active-high reset returns the controller to idle; stores are not cleared
`default_nettype none

module tile_map_renderer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // address[11:0], data[19:12], tile_col[24:20], tile_row[29:25], zero fill
  input  wire logic [tmr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // pixel_x[7:0], pixel_y[15:8], color_index[17:16], red[25:18], green[33:26],
  // blue[41:34], zero fill
  output logic [tmr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast
);

  tmr_pkg::cmd_t    cmd;
  tmr_pkg::status_t status;

  tmr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  tmr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .cmd          (cmd),
    .status       (status),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

### rtl/core/tmr_checker.sv
`default_nettype none
`include "tile_map_renderer_defines.svh"

module tmr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [1:0] s_axis_tuser,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic       m_axis_tlast
);

  logic render_txn, out_txn;

  assign render_txn = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tmr_pkg::ACT_RENDER);
  assign out_txn    = m_axis_tvalid && m_axis_tready;

  // one item at a time: no input while pixels are pending
  `TMR_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken during render")

  // a render starts emitting after the map and tile reads
  `TMR_ASSERT_NEXT(a_render_start, render_txn,
                   !m_axis_tvalid ##1 !m_axis_tvalid ##1 m_axis_tvalid,
                   "render did not start on time")

  // pixels run without gaps until the last one
  `TMR_ASSERT_NEXT(a_no_gap, out_txn && !m_axis_tlast, m_axis_tvalid, "gap inside tile")

  // after the last pixel the block is idle and ready
  `TMR_ASSERT_NEXT(a_back_idle, out_txn && m_axis_tlast, s_axis_tready && !m_axis_tvalid,
                   "not idle after last pixel")

endmodule

bind tile_map_renderer tmr_checker u_tmr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
